/* hdl/strip_vertex_dequant_assembler_macros.svh */
// Assertion macros shared by the strip vertex dequant assembler.
// Expects clk and arst_n in the scope of use.
`ifndef STRIP_VERTEX_DEQUANT_ASSEMBLER_MACROS_SVH
`define STRIP_VERTEX_DEQUANT_ASSEMBLER_MACROS_SVH

// check a property on every rising clock edge outside reset
`define SVDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition never holds
`define SVDA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hdl/svda_pkg.sv */
// Shared types and constants of the strip vertex dequant assembler.
// No dependencies.
package svda_pkg;

	localparam logic [7:0] EXP_BASE = 8'h49;

	localparam logic [2:0] REG_SCALE_EXP_X = 3'd0;
	localparam logic [2:0] REG_SCALE_EXP_Y = 3'd1;
	localparam logic [2:0] REG_SCALE_EXP_Z = 3'd2;
	localparam logic [2:0] REG_DOUBLE_MASK = 3'd3;
	localparam logic [2:0] REG_OFFSET_X    = 3'd4;
	localparam logic [2:0] REG_OFFSET_Y    = 3'd5;
	localparam logic [2:0] REG_OFFSET_Z    = 3'd6;

	// input word, pos_x in the lowest bits
	typedef struct packed {
		logic [7:0]         attr_c;
		logic [7:0]         attr_b;
		logic [7:0]         attr_a;
		logic signed [15:0] tex_v;
		logic signed [15:0] tex_u;
		logic [15:0]        pos_z;
		logic [15:0]        pos_y;
		logic [15:0]        pos_x;
	} in_word_t;

	// dequantized vertex, equal to one output corner word
	typedef struct packed {
		logic [7:0]         attr_c;
		logic [7:0]         attr_b;
		logic [7:0]         attr_a;
		logic signed [15:0] tex_v;
		logic signed [15:0] tex_u;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} vertex_t;

endpackage

/* hdl/svda_axis.sv */
// One position axis: power-of-two scale, offset add and 32-bit saturation.
// Uses svda_pkg.
module svda_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic [15:0]        q,
	input  logic [7:0]         scale_exp,
	input  logic               dbl,
	input  logic signed [32:0] offset,
	output logic signed [31:0] result
);
	import svda_pkg::*;

	localparam int SH_BASE = FRAC_BITS - 6;
	localparam int SW      = 16 + SH_BASE + 1;
	localparam int SUMW    = ((SW > 32) ? SW : 32) + 2;

	logic [6:0]        k;
	logic [7:0]        k2;
	logic [7:0]        base;
	logic [7:0]        lsh;
	logic [7:0]        rsh;
	logic [15:0]       q_rs;
	logic [SW-1:0]     scaled;
	logic [SUMW-1:0]   sum;
	logic [SUMW-32:0]  hi;

	always_comb begin
		k    = (scale_exp < EXP_BASE) ? 7'(EXP_BASE - scale_exp) : 7'd0;
		k2   = {k, 1'b0};
		base = 8'(SH_BASE) + {7'd0, dbl};
		lsh  = base - k2;
		rsh  = k2 - base;
		q_rs = q >> rsh[4:0];
		if (k2 <= base) begin
			scaled = {{(SW-16){1'b0}}, q} << lsh[4:0];
		end else if (rsh >= 8'd32) begin
			scaled = '0;
		end else begin
			scaled = {{(SW-16){1'b0}}, q_rs};
		end
		sum = {{(SUMW-SW){1'b0}}, scaled} + {{(SUMW-33){offset[32]}}, offset};
		hi  = sum[SUMW-1:31];
		if ((&hi) || !(|hi)) begin
			result = sum[31:0];
		end else if (sum[SUMW-1]) begin
			result = 32'sh8000_0000;
		end else begin
			result = 32'sh7fff_ffff;
		end
	end

endmodule

/* hdl/svda_strip.sv */
// Strip restart tracking, vertex history and triangle corner output buffer.
// Uses svda_pkg and the assertion macro header.
`include "strip_vertex_dequant_assembler_macros.svh"

module svda_strip (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  logic              first_s1,
	input  svda_pkg::vertex_t cur,
	output logic              take,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [151:0]      m_tdata,
	output logic              m_tlast
);
	import svda_pkg::*;

	logic       in_first_q;
	logic       mark_q;
	logic [1:0] fill_q;
	vertex_t    hist_q [2];
	vertex_t    tri_q  [3];
	logic       tri_vld_q;
	logic [1:0] corner_q;

	logic       ifs0, mp0, ifs1, mp1, restart;
	logic [1:0] fill0, fill1, fill_nxt;
	logic       emit;
	logic       out_free;

	always_comb begin
		ifs0    = first_s1 ? 1'b1 : in_first_q;
		mp0     = first_s1 ? 1'b0 : mark_q;
		fill0   = first_s1 ? 2'd0 : fill_q;
		ifs1    = ifs0;
		mp1     = mp0;
		restart = 1'b0;
		if (cur.tex_u[0]) begin
			if (ifs0) begin
				ifs1 = 1'b0;
			end else if (!mp0) begin
				mp1 = 1'b1;
			end else begin
				mp1     = 1'b0;
				restart = 1'b1;
			end
		end
		fill1    = restart ? 2'd0 : fill0;
		emit     = (fill1 == 2'd2);
		fill_nxt = emit ? 2'd2 : fill1 + 2'd1;
	end

	assign out_free = !tri_vld_q || (m_tready && corner_q == 2'd2);
	assign take     = vld_s1 && (!emit || out_free);
	assign m_tvalid = tri_vld_q;
	assign m_tlast  = (corner_q == 2'd2);
	assign m_tdata  = tri_q[corner_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_first_q <= 1'b1;
			mark_q     <= 1'b0;
			fill_q     <= 2'd0;
			tri_vld_q  <= 1'b0;
			corner_q   <= 2'd0;
		end else begin
			if (take && emit) begin
				tri_vld_q <= 1'b1;
				corner_q  <= 2'd0;
			end else if (tri_vld_q && m_tready) begin
				if (corner_q == 2'd2) begin
					tri_vld_q <= 1'b0;
					corner_q  <= 2'd0;
				end else begin
					corner_q <= corner_q + 2'd1;
				end
			end
			if (take) begin
				in_first_q <= ifs1;
				mark_q     <= mp1;
				fill_q     <= fill_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hist_q[0] <= hist_q[1];
			hist_q[1] <= cur;
			if (emit) begin
				tri_q[0] <= hist_q[0];
				tri_q[1] <= hist_q[1];
				tri_q[2] <= cur;
			end
		end
	end

	`SVDA_ASSERT(a_load_starts, take && emit |=> m_tvalid && corner_q == 2'd0, "triangle not loaded")
	`SVDA_ASSERT(a_hold_corner, m_tvalid && !m_tready |=> m_tvalid && $stable(corner_q), "corner moved while stalled")
	`SVDA_ASSERT(a_mid_tri, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "triangle cut short")
	`SVDA_NEVER(a_fill_range, fill_q == 2'd3, "strip fill overflow")
	`SVDA_NEVER(a_no_overwrite, take && emit && tri_vld_q && !(m_tready && m_tlast), "pending triangle overwritten")

endmodule

/* hdl/strip_vertex_dequant_assembler.sv */
// Top level: config registers, input register and the three position axes.
// Uses svda_pkg, svda_axis and svda_strip.
//
//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | s_tdata vertex, s_tuser first_of_mesh
//  m       | out       | m_tvalid/m_tready  | m_tdata corner, m_tlast last_corner
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A vertex is registered, dequantized and shifted into the history once the strip takes it.
// A vertex that closes a triangle occupies the corner buffer for its three corner words;
// the next closing vertex waits until the last corner is being taken, while filling vertices flow
// at one per cycle. Output stalls back up into the input register and then s_tready.
// Reset clears strip state and restores the config register defaults; cfg_ready is high.
module strip_vertex_dequant_assembler #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, attr_a, attr_b, attr_c
	input  logic         s_tuser,   // first_of_mesh
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // out_pos_x, out_pos_y, out_pos_z, out_u, out_v,
	                                // out_attr_a, out_attr_b, out_attr_c
	output logic         m_tlast,   // last_corner
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import svda_pkg::*;

	logic [7:0]         exp_x_q, exp_y_q, exp_z_q;
	logic [2:0]         dbl_q;
	logic signed [31:0] off_x_q, off_y_q, off_z_q;

	logic               vld_s1;
	logic               first_s1;
	in_word_t           in_s1;

	logic signed [32:0] off_x33, off_y33, off_z33;
	vertex_t            cur;
	logic               take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_x_q <= EXP_BASE;
			exp_y_q <= EXP_BASE;
			exp_z_q <= EXP_BASE;
			dbl_q   <= 3'd0;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCALE_EXP_X: exp_x_q <= cfg_data[7:0];
				REG_SCALE_EXP_Y: exp_y_q <= cfg_data[7:0];
				REG_SCALE_EXP_Z: exp_z_q <= cfg_data[7:0];
				REG_DOUBLE_MASK: dbl_q   <= cfg_data[2:0];
				REG_OFFSET_X:    off_x_q <= cfg_data;
				REG_OFFSET_Y:    off_y_q <= cfg_data;
				REG_OFFSET_Z:    off_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1    <= in_word_t'(s_tdata);
			first_s1 <= s_tuser;
		end
	end

	assign off_x33 = 33'sd0 - {off_x_q[31], off_x_q};
	assign off_y33 = {off_y_q[31], off_y_q};
	assign off_z33 = {off_z_q[31], off_z_q};

	svda_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.q(in_s1.pos_x), .scale_exp(exp_x_q), .dbl(dbl_q[0]), .offset(off_x33),
		.result(cur.pos_x)
	);
	svda_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.q(in_s1.pos_y), .scale_exp(exp_y_q), .dbl(dbl_q[1]), .offset(off_y33),
		.result(cur.pos_y)
	);
	svda_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
		.q(in_s1.pos_z), .scale_exp(exp_z_q), .dbl(dbl_q[2]), .offset(off_z33),
		.result(cur.pos_z)
	);

	assign cur.tex_u  = in_s1.tex_u;
	assign cur.tex_v  = in_s1.tex_v;
	assign cur.attr_a = in_s1.attr_a;
	assign cur.attr_b = in_s1.attr_b;
	assign cur.attr_c = in_s1.attr_c;

	svda_strip u_strip (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.first_s1(first_s1),
		.cur(cur),
		.take(take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

/* tb/tb_strip_vertex_dequant_assembler.sv */
// Testbench for strip_vertex_dequant_assembler: directed and random vertex streams,
// checked corner by corner against an in-bench dequantizer and strip assembler.
// Depends on svda_pkg and the strip_vertex_dequant_assembler RTL.
module tb_strip_vertex_dequant_assembler;
	import svda_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;

	typedef struct {
		vertex_t corner;
		logic    last;
	} predicted_corner_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;  // pos_x, pos_y, pos_z, tex_u, tex_v, attr_a, attr_b, attr_c
	logic         s_tuser = 1'b0; // first_of_mesh
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;        // out_pos_x, out_pos_y, out_pos_z, out_u, out_v,
	                              // out_attr_a, out_attr_b, out_attr_c
	logic         m_tlast;        // last_corner
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	// configuration mirror
	logic [7:0]         exp_x = EXP_BASE;
	logic [7:0]         exp_y = EXP_BASE;
	logic [7:0]         exp_z = EXP_BASE;
	logic [2:0]         double_mask = 3'd0;
	logic signed [31:0] ofs_x = 32'sd0;
	logic signed [31:0] ofs_y = 32'sd0;
	logic signed [31:0] ofs_z = 32'sd0;

	// strip mirror
	bit      first_strip_open = 1'b1;
	bit      mark_pending = 1'b0;
	int      strip_fill = 0;
	vertex_t hist_older = '0;
	vertex_t hist_prev = '0;

	predicted_corner_t predicted_corners[$];

	int  mismatch_count = 0;
	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	logic hold_request = 1'b0;
	bit  hold_taken = 1'b0;
	int  hold_left = 0;
	int  stall_cycles = 0;

	strip_vertex_dequant_assembler #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic signed [31:0] dequant_axis(logic [15:0] q, logic [7:0] e,
			logic dbl, logic signed [31:0] ofs, bit subtract);
		int     k;
		int     sh;
		longint v;
		k = (e < EXP_BASE) ? int'(EXP_BASE - e) : 0;
		sh = FRAC_BITS - 6 - 2 * k + int'(dbl);
		if (sh >= 0)
			v = longint'(q) << sh;
		else if (-sh >= 32)
			v = 0;
		else
			v = longint'(q) >> (-sh);
		v = subtract ? v - longint'(ofs) : v + longint'(ofs);
		if (v > SAT_MAX)
			v = SAT_MAX;
		if (v < SAT_MIN)
			v = SAT_MIN;
		return v[31:0];
	endfunction

	function automatic void queue_corner(vertex_t c, logic last);
		predicted_corner_t p;
		p.corner = c;
		p.last = last;
		predicted_corners.insert(predicted_corners.size(), p);
	endfunction

	function automatic void assemble_vertex(bit first, in_word_t w);
		vertex_t cur;
		bit      restart;
		restart = 1'b0;
		if (first) begin
			first_strip_open = 1'b1;
			mark_pending = 1'b0;
			strip_fill = 0;
		end
		if (w.tex_u[0]) begin
			if (first_strip_open) begin
				first_strip_open = 1'b0;
			end else if (!mark_pending) begin
				mark_pending = 1'b1;
			end else begin
				mark_pending = 1'b0;
				restart = 1'b1;
			end
		end
		if (restart)
			strip_fill = 0;
		cur.pos_x = dequant_axis(w.pos_x, exp_x, double_mask[0], ofs_x, 1'b1);
		cur.pos_y = dequant_axis(w.pos_y, exp_y, double_mask[1], ofs_y, 1'b0);
		cur.pos_z = dequant_axis(w.pos_z, exp_z, double_mask[2], ofs_z, 1'b0);
		cur.tex_u = w.tex_u;
		cur.tex_v = w.tex_v;
		cur.attr_a = w.attr_a;
		cur.attr_b = w.attr_b;
		cur.attr_c = w.attr_c;
		if (strip_fill >= 2) begin
			queue_corner(hist_older, 1'b0);
			queue_corner(hist_prev, 1'b0);
			queue_corner(cur, 1'b1);
		end
		hist_older = hist_prev;
		hist_prev = cur;
		if (strip_fill < 2)
			strip_fill++;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_corner();
		predicted_corner_t want;
		vertex_t           got;
		if (predicted_corners.size() == 0) begin
			$error("corner word with no prediction pending");
			mismatch_count++;
			return;
		end
		want = predicted_corners.pop_front();
		got = m_tdata;
		compare_field("out_pos_x", want.corner.pos_x, got.pos_x);
		compare_field("out_pos_y", want.corner.pos_y, got.pos_y);
		compare_field("out_pos_z", want.corner.pos_z, got.pos_z);
		compare_field("out_u", {16'd0, want.corner.tex_u}, {16'd0, got.tex_u});
		compare_field("out_v", {16'd0, want.corner.tex_v}, {16'd0, got.tex_v});
		compare_field("out_attr_a", {24'd0, want.corner.attr_a}, {24'd0, got.attr_a});
		compare_field("out_attr_b", {24'd0, want.corner.attr_b}, {24'd0, got.attr_b});
		compare_field("out_attr_c", {24'd0, want.corner.attr_c}, {24'd0, got.attr_c});
		compare_field("last_corner", {31'd0, want.last}, {31'd0, m_tlast});
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_corner();
			if (hold_request && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_vertex(bit first, in_word_t w);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		assemble_vertex(first, w);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SCALE_EXP_X: exp_x = data[7:0];
			REG_SCALE_EXP_Y: exp_y = data[7:0];
			REG_SCALE_EXP_Z: exp_z = data[7:0];
			REG_DOUBLE_MASK: double_mask = data[2:0];
			REG_OFFSET_X:    ofs_x = data;
			REG_OFFSET_Y:    ofs_y = data;
			REG_OFFSET_Z:    ofs_z = data;
			default: ;
		endcase
	endtask

	task automatic apply_config(logic [7:0] ex, logic [7:0] ey, logic [7:0] ez,
			logic [2:0] mask, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
		write_reg(REG_SCALE_EXP_X, {24'd0, ex});
		write_reg(REG_SCALE_EXP_Y, {24'd0, ey});
		write_reg(REG_SCALE_EXP_Z, {24'd0, ez});
		write_reg(REG_DOUBLE_MASK, {29'd0, mask});
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, drain all predicted corners, then let in-flight vertices settle
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (predicted_corners.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic in_word_t make_vertex(logic [15:0] px, logic [15:0] py,
			logic [15:0] pz, logic [15:0] u, logic [15:0] v, logic [23:0] attrs);
		in_word_t w;
		w.pos_x = px;
		w.pos_y = py;
		w.pos_z = pz;
		w.tex_u = u;
		w.tex_v = v;
		{w.attr_c, w.attr_b, w.attr_a} = attrs;
		return w;
	endfunction

	function automatic logic [15:0] pick_pos();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t random_vertex();
		in_word_t w;
		w = make_vertex(pick_pos(), pick_pos(), pick_pos(), 16'($urandom), 16'($urandom),
			24'($urandom));
		w.tex_u[0] = ($urandom_range(99) < 25);
		return w;
	endfunction

	function automatic logic [7:0] pick_exp();
		case ($urandom_range(4))
			0: return EXP_BASE;
			1: return 8'($urandom_range(8'h40, 8'h52));
			2: return 8'($urandom);
			3: return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h007F_FFFF;
			2: return $urandom;
			3: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	task automatic send_random_vertices(int count);
		for (int i = 0; i < count; i++)
			send_vertex(($urandom_range(99) < 4) || (i == 0), random_vertex());
	endtask

	task automatic test_first_strip();
		send_vertex(1'b1, make_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h0));
		send_vertex(1'b0, make_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFE, 16'h8000,
			24'hFFFFFF));
		send_vertex(1'b0, make_vertex(16'h8000, 16'h1234, 16'h00FF, 16'h8000, 16'h7FFF,
			24'h5AA5C3));
		send_vertex(1'b0, make_vertex(16'h0001, 16'h7FFF, 16'hFF00, 16'h3456, 16'hFFFF,
			24'h0180FE));
		settle_block();
	endtask

	task automatic test_restart_marks();
		bit [12:0] marks;
		bit [12:0] firsts;
		marks  = 13'b0_0101_0100_0001;
		firsts = 13'b0_0100_0000_0001;
		for (int i = 0; i < 13; i++) begin
			in_word_t w;
			w = random_vertex();
			w.tex_u[0] = marks[i];
			send_vertex(firsts[i], w);
		end
		settle_block();
	endtask

	task automatic test_scale_extremes();
		apply_config(8'hFF, 8'h00, 8'h44, 3'b111, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_vertex(1'b1, make_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0010, 16'h0020, 24'h1));
		send_vertex(1'b0, make_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'h0040, 24'h2));
		send_vertex(1'b0, random_vertex());
		settle_block();
		// stored vertices keep their old scaling across this change
		apply_config(8'h43, 8'h34, 8'h33, 3'b000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_vertex(1'b0, make_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0050, 16'h0060, 24'h3));
		send_vertex(1'b0, make_vertex(16'h0003, 16'h0000, 16'h8000, 16'h0070, 16'h0080, 24'h4));
		send_vertex(1'b0, random_vertex());
		settle_block();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 70;
				end
				1: begin
					tx_idle_pct = 70;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			settle_block();
			apply_config(pick_exp(), pick_exp(), pick_exp(), 3'($urandom), pick_offset(),
				pick_offset(), pick_offset());
			send_random_vertices(75);
		end
		settle_block();
	endtask

	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_config(EXP_BASE, 8'h47, 8'h4A, 3'b101, pick_offset(), pick_offset(),
			pick_offset());
		hold_request <= 1'b1;
		send_random_vertices(30);
		settle_block();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_strip();
		test_restart_marks();
		test_scale_extremes();
		test_random_traffic();
		test_output_backpressure();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
